// File: hw/rtl/efpw_pkg.sv
// Shared types, constants and the Gaussian lookup table for the
// exposure-fusion pixel weight block. No dependencies.
package efpw_pkg;

    // Input samples are unsigned value/1024, clamped to 1.0.
    localparam int IN_W = 11;
    localparam logic [IN_W-1:0] ONE_IN = 11'd1024;

    // Fraction bits of the weight output.
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_W = 17;
    localparam int FRAC_W = 16;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 17'd131071;

    // Internal widths.
    localparam int CONTRAST_W = 13;   // |Laplacian|, 0..4096, Q.10
    localparam int CONTRAST_FRAC = 10;
    localparam int GAUSS_W = 17;      // 0..65536, Q.16
    localparam int SQ_W = 21;         // one channel squared
    localparam int SUM_W = 12;        // r + g + b
    localparam int QSUM_W = 22;       // r^2 + g^2 + b^2
    localparam int TRIPLE_W = 24;     // 3q and s^2
    localparam int VAR_W = 22;        // 3q - s^2, at most 2^21
    localparam int RAD_W = 30;        // floor(var * 4096 / 9)
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W = ROOT_W + 2;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int CS_W = CONTRAST_W + FRAC_W;
    localparam int PROD_W = CS_W + GAUSS_W;
    localparam int PROD_FRAC = CONTRAST_FRAC + 2 * FRAC_W;
    localparam int WEIGHT_SHIFT = PROD_FRAC - WEIGHT_FRAC_BITS;

    // var * 4096 / 9 = var * 455 + var / 9, since 4096 = 9 * 455 + 1.
    // var / 9 is a multiply by a rounded-up reciprocal, exact for 22 bits.
    localparam int SCALE_INT = 455;
    localparam int RECIP9_W = 23;
    localparam logic [RECIP9_W-1:0] RECIP9 = 23'd7456541;
    localparam int RECIP9_SHIFT = 26;
    localparam int RECIP_PROD_W = VAR_W + RECIP9_W;
    localparam int QUOT9_W = RECIP_PROD_W - RECIP9_SHIFT;

    // Pipeline depth from transfer to result strobe.
    localparam int LATENCY = 9 + SQRT_STEPS;

    typedef struct packed {
        logic [IN_W-1:0] red;
        logic [IN_W-1:0] green;
        logic [IN_W-1:0] blue;
        logic [IN_W-1:0] gray_center;
        logic [IN_W-1:0] gray_up;
        logic [IN_W-1:0] gray_down;
        logic [IN_W-1:0] gray_left;
        logic [IN_W-1:0] gray_right;
    } pixel_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [FRAC_W-1:0]   saturation;
        logic [FRAC_W-1:0]   exposedness;
    } result_t;

    // 65536 * exp(-12.5 * (k/32)^2) for k = 0..16.
    function automatic logic [GAUSS_W-1:0] gauss_entry(input logic [4:0] idx);
        logic [GAUSS_W-1:0] e;
        case (idx)
            5'd0:    e = 17'd65536;
            5'd1:    e = 17'd64741;
            5'd2:    e = 17'd62413;
            5'd3:    e = 17'd58717;
            5'd4:    e = 17'd53908;
            5'd5:    e = 17'd48300;
            5'd6:    e = 17'd42231;
            5'd7:    e = 17'd36034;
            5'd8:    e = 17'd30005;
            5'd9:    e = 17'd24382;
            5'd10:   e = 17'd19335;
            5'd11:   e = 17'd14963;
            5'd12:   e = 17'd11300;
            5'd13:   e = 17'd8328;
            5'd14:   e = 17'd5990;
            5'd15:   e = 17'd4204;
            default: e = 17'd2879;
        endcase
        return e;
    endfunction

endpackage

// File: hw/rtl/exposure_fusion_pixel_weight.sv
// Top level of the exposure-fusion pixel weight pipeline.
// Depends on efpw_pkg for the payload structs, widths and Gaussian table.

// One pixel is taken per clock: a transfer happens at every rising edge
// where start is high, and busy is never raised, so pixels may stream
// back to back without gaps. Each transfer produces exactly one result,
// shown on result for a single cycle with done high. Done and result are
// both registered at the last stage of the pipeline, whose depth is
// efpw_pkg::LATENCY, so the two always show in the same cycle. Results
// come out in the order the pixels went in. The receiver cannot stall the
// block, so it must be ready to take a result in every cycle. The depth
// is set mostly by the square root for the saturation term, which
// resolves one result bit per pipeline stage over fifteen stages; the
// remaining stages hold input clamping, the squares and Gaussian lookup,
// the variance, the scaling by 4096/9, rounding of the root, and the two
// multiplies and final rounding of the weight. Input samples above 1024
// are clamped to 1024. There is no configuration and no internal state
// beyond the pipeline itself.
module exposure_fusion_pixel_weight (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  efpw_pkg::pixel_t   pixel,
    output logic               done,
    output efpw_pkg::result_t  result
);

    // Stage 1: clamped inputs.
    typedef struct packed {
        logic [efpw_pkg::IN_W-1:0] r;
        logic [efpw_pkg::IN_W-1:0] g;
        logic [efpw_pkg::IN_W-1:0] b;
        logic [efpw_pkg::IN_W-1:0] gc;
        logic [efpw_pkg::IN_W-1:0] gu;
        logic [efpw_pkg::IN_W-1:0] gd;
        logic [efpw_pkg::IN_W-1:0] gl;
        logic [efpw_pkg::IN_W-1:0] gr;
    } st1_t;

    // Stage 2: channel sum, squares, contrast and per-channel Gaussians.
    typedef struct packed {
        logic [efpw_pkg::SUM_W-1:0]      sum;
        logic [efpw_pkg::SQ_W-1:0]       sq_r;
        logic [efpw_pkg::SQ_W-1:0]       sq_g;
        logic [efpw_pkg::SQ_W-1:0]       sq_b;
        logic [efpw_pkg::CONTRAST_W-1:0] contrast;
        logic [efpw_pkg::GAUSS_W-1:0]    g_r;
        logic [efpw_pkg::GAUSS_W-1:0]    g_g;
        logic [efpw_pkg::GAUSS_W-1:0]    g_b;
    } st2_t;

    // Stage 3: variance term and the first Gaussian product.
    typedef struct packed {
        logic [efpw_pkg::VAR_W-1:0]      var3;
        logic [efpw_pkg::GAUSS_W-1:0]    expo_rg;
        logic [efpw_pkg::GAUSS_W-1:0]    g_b;
        logic [efpw_pkg::CONTRAST_W-1:0] contrast;
    } st3_t;

    // Stage 4: the two parts of var * 4096 / 9 and the full exposedness.
    typedef struct packed {
        logic [efpw_pkg::QUOT9_W-1:0]    quot9;
        logic [efpw_pkg::RAD_W-1:0]      scaled;
        logic [efpw_pkg::GAUSS_W-1:0]    expo;
        logic [efpw_pkg::CONTRAST_W-1:0] contrast;
    } st4_t;

    // Stages after the root: rounded saturation, then the weight products.
    typedef struct packed {
        logic [efpw_pkg::FRAC_W-1:0]     sat;
        logic [efpw_pkg::GAUSS_W-1:0]    expo;
        logic [efpw_pkg::CONTRAST_W-1:0] contrast;
    } st_sat_t;

    typedef struct packed {
        logic [efpw_pkg::CS_W-1:0]    cs;
        logic [efpw_pkg::FRAC_W-1:0]  sat;
        logic [efpw_pkg::GAUSS_W-1:0] expo;
    } st_cs_t;

    typedef struct packed {
        logic [efpw_pkg::PROD_W-1:0]  prod;
        logic [efpw_pkg::FRAC_W-1:0]  sat;
        logic [efpw_pkg::GAUSS_W-1:0] expo;
    } st_prod_t;

    localparam int RND_W = efpw_pkg::PROD_W + 1;

    function automatic logic [efpw_pkg::IN_W-1:0] clamp_in(
        input logic [efpw_pkg::IN_W-1:0] x
    );
        return (x > efpw_pkg::ONE_IN) ? efpw_pkg::ONE_IN : x;
    endfunction

    // Piecewise-linear Gaussian around 0.5 from the 17-entry table.
    function automatic logic [efpw_pkg::GAUSS_W-1:0] gauss_eval(
        input logic [efpw_pkg::IN_W-1:0] x
    );
        logic [efpw_pkg::IN_W-1:0]       d;
        logic [4:0]                      k;
        logic [4:0]                      f;
        logic [efpw_pkg::GAUSS_W-1:0]    e0;
        logic [efpw_pkg::GAUSS_W-1:0]    e1;
        logic [12:0]                     diff;
        logic [17:0]                     corr;
        logic [efpw_pkg::GAUSS_W-1:0]    g;
        d    = (x >= 11'd512) ? (x - 11'd512) : (11'd512 - x);
        k    = d[9:5];
        f    = d[4:0];
        e0   = efpw_pkg::gauss_entry(k);
        e1   = efpw_pkg::gauss_entry(k + 5'd1);
        diff = 13'(e0 - e1);
        corr = (18'(diff) * 18'(f) + 18'd16) >> 5;
        if (k >= 5'd16)
            g = efpw_pkg::gauss_entry(5'd16);
        else
            g = e0 - efpw_pkg::GAUSS_W'(corr);
        return g;
    endfunction

    logic                          accept;
    logic [efpw_pkg::LATENCY-1:0]  vld_reg;
    logic [efpw_pkg::LATENCY-1:0]  vld_next;

    st1_t     st1_reg, st1_next;
    st2_t     st2_reg, st2_next;
    st3_t     st3_reg, st3_next;
    st4_t     st4_reg, st4_next;
    st_sat_t  sat_reg, sat_next;
    st_cs_t   cs_reg, cs_next;
    st_prod_t prod_reg, prod_next;
    efpw_pkg::result_t result_reg, result_next;

    // Square-root pipeline. Entry 0 holds the radicand; each later entry
    // holds one more resolved root bit.
    logic [efpw_pkg::RAD_W-1:0]      sq_rad_reg  [0:efpw_pkg::SQRT_STEPS];
    logic [efpw_pkg::REM_W-1:0]      sq_rem_reg  [0:efpw_pkg::SQRT_STEPS];
    logic [efpw_pkg::ROOT_W-1:0]     sq_root_reg [0:efpw_pkg::SQRT_STEPS];
    logic [efpw_pkg::GAUSS_W-1:0]    sq_expo_reg [0:efpw_pkg::SQRT_STEPS];
    logic [efpw_pkg::CONTRAST_W-1:0] sq_con_reg  [0:efpw_pkg::SQRT_STEPS];
    logic [efpw_pkg::RAD_W-1:0]      sq_rad_next  [0:efpw_pkg::SQRT_STEPS];
    logic [efpw_pkg::REM_W-1:0]      sq_rem_next  [0:efpw_pkg::SQRT_STEPS];
    logic [efpw_pkg::ROOT_W-1:0]     sq_root_next [0:efpw_pkg::SQRT_STEPS];

    // The pipeline never stalls, so a pixel is taken whenever offered.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign vld_next = {vld_reg[efpw_pkg::LATENCY-2:0], accept};

    // Stage 1: clamp every sample to 1.0.
    always_comb
    begin
        st1_next.r  = clamp_in(pixel.red);
        st1_next.g  = clamp_in(pixel.green);
        st1_next.b  = clamp_in(pixel.blue);
        st1_next.gc = clamp_in(pixel.gray_center);
        st1_next.gu = clamp_in(pixel.gray_up);
        st1_next.gd = clamp_in(pixel.gray_down);
        st1_next.gl = clamp_in(pixel.gray_left);
        st1_next.gr = clamp_in(pixel.gray_right);
    end

    // Stage 2: contrast is the magnitude of the 4-neighbor Laplacian.
    logic [efpw_pkg::CONTRAST_W-1:0] nsum;
    logic [efpw_pkg::CONTRAST_W-1:0] center4;

    always_comb
    begin
        nsum    = efpw_pkg::CONTRAST_W'(st1_reg.gu) + efpw_pkg::CONTRAST_W'(st1_reg.gd)
                + efpw_pkg::CONTRAST_W'(st1_reg.gl) + efpw_pkg::CONTRAST_W'(st1_reg.gr);
        center4 = {st1_reg.gc, 2'b00};
        st2_next.contrast = (nsum >= center4) ? (nsum - center4) : (center4 - nsum);
        st2_next.sum  = efpw_pkg::SUM_W'(st1_reg.r) + efpw_pkg::SUM_W'(st1_reg.g)
                      + efpw_pkg::SUM_W'(st1_reg.b);
        st2_next.sq_r = efpw_pkg::SQ_W'(st1_reg.r) * efpw_pkg::SQ_W'(st1_reg.r);
        st2_next.sq_g = efpw_pkg::SQ_W'(st1_reg.g) * efpw_pkg::SQ_W'(st1_reg.g);
        st2_next.sq_b = efpw_pkg::SQ_W'(st1_reg.b) * efpw_pkg::SQ_W'(st1_reg.b);
        st2_next.g_r  = gauss_eval(st1_reg.r);
        st2_next.g_g  = gauss_eval(st1_reg.g);
        st2_next.g_b  = gauss_eval(st1_reg.b);
    end

    // Stage 3: 3q - s^2 is nine times the channel variance.
    logic [efpw_pkg::QSUM_W-1:0]   qsum;
    logic [efpw_pkg::TRIPLE_W-1:0] q3;
    logic [efpw_pkg::TRIPLE_W-1:0] ssq;
    logic [33:0]                   prod_rg;

    always_comb
    begin
        qsum = efpw_pkg::QSUM_W'(st2_reg.sq_r) + efpw_pkg::QSUM_W'(st2_reg.sq_g)
             + efpw_pkg::QSUM_W'(st2_reg.sq_b);
        q3   = efpw_pkg::TRIPLE_W'(qsum) * efpw_pkg::TRIPLE_W'(3);
        ssq  = efpw_pkg::TRIPLE_W'(st2_reg.sum) * efpw_pkg::TRIPLE_W'(st2_reg.sum);
        st3_next.var3 = (q3 >= ssq) ? efpw_pkg::VAR_W'(q3 - ssq) : '0;
        prod_rg = 34'(st2_reg.g_r) * 34'(st2_reg.g_g) + 34'd32768;
        st3_next.expo_rg  = prod_rg[32:16];
        st3_next.g_b      = st2_reg.g_b;
        st3_next.contrast = st2_reg.contrast;
    end

    // Stage 4: integer and fractional parts of var * 4096 / 9.
    logic [efpw_pkg::RECIP_PROD_W-1:0] recip_prod;
    logic [33:0]                       prod_rgb;

    always_comb
    begin
        recip_prod = efpw_pkg::RECIP_PROD_W'(st3_reg.var3)
                   * efpw_pkg::RECIP_PROD_W'(efpw_pkg::RECIP9);
        st4_next.quot9  = recip_prod[efpw_pkg::RECIP_PROD_W-1:efpw_pkg::RECIP9_SHIFT];
        st4_next.scaled = efpw_pkg::RAD_W'(st3_reg.var3)
                        * efpw_pkg::RAD_W'(efpw_pkg::SCALE_INT);
        prod_rgb = 34'(st3_reg.expo_rg) * 34'(st3_reg.g_b) + 34'd32768;
        st4_next.expo     = prod_rgb[32:16];
        st4_next.contrast = st3_reg.contrast;
    end

    // Square root, one result bit per stage, keeping the remainder for
    // round-to-nearest at the end.
    logic [efpw_pkg::REM_W+1:0] rem_trial [0:efpw_pkg::SQRT_STEPS-1];
    logic [efpw_pkg::REM_W+1:0] sub_trial [0:efpw_pkg::SQRT_STEPS-1];

    always_comb
    begin
        sq_rad_next[0]  = st4_reg.scaled + efpw_pkg::RAD_W'(st4_reg.quot9);
        sq_rem_next[0]  = '0;
        sq_root_next[0] = '0;
        for (int j = 0; j < efpw_pkg::SQRT_STEPS; j++)
        begin
            rem_trial[j] = {sq_rem_reg[j], sq_rad_reg[j][efpw_pkg::RAD_W-1 -: 2]};
            sub_trial[j] = (efpw_pkg::REM_W+2)'({sq_root_reg[j], 2'b01});
            sq_rad_next[j+1] = sq_rad_reg[j] << 2;
            if (rem_trial[j] >= sub_trial[j])
            begin
                sq_rem_next[j+1]  = efpw_pkg::REM_W'(rem_trial[j] - sub_trial[j]);
                sq_root_next[j+1] = {sq_root_reg[j][efpw_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[j+1]  = efpw_pkg::REM_W'(rem_trial[j]);
                sq_root_next[j+1] = {sq_root_reg[j][efpw_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Rounding: the root goes up by one when the remainder exceeds it.
    logic [efpw_pkg::ROOT_W-1:0] root_fin;
    logic [efpw_pkg::REM_W-1:0]  rem_fin;

    always_comb
    begin
        root_fin = sq_root_reg[efpw_pkg::SQRT_STEPS];
        rem_fin  = sq_rem_reg[efpw_pkg::SQRT_STEPS];
        sat_next.sat = efpw_pkg::FRAC_W'(root_fin)
                     + efpw_pkg::FRAC_W'(rem_fin > efpw_pkg::REM_W'(root_fin));
        sat_next.expo     = sq_expo_reg[efpw_pkg::SQRT_STEPS];
        sat_next.contrast = sq_con_reg[efpw_pkg::SQRT_STEPS];
    end

    always_comb
    begin
        cs_next.cs   = efpw_pkg::CS_W'(sat_reg.contrast) * efpw_pkg::CS_W'(sat_reg.sat);
        cs_next.sat  = sat_reg.sat;
        cs_next.expo = sat_reg.expo;
    end

    always_comb
    begin
        prod_next.prod = efpw_pkg::PROD_W'(cs_reg.cs) * efpw_pkg::PROD_W'(cs_reg.expo);
        prod_next.sat  = cs_reg.sat;
        prod_next.expo = cs_reg.expo;
    end

    // Output stage: round the Q.42 product to the weight format, add the
    // one-LSB floor, and saturate. Perfect exposure (1.0) reads as 65535.
    logic [RND_W-1:0] rnd;
    logic [RND_W-1:0] wsum;

    always_comb
    begin
        rnd  = RND_W'(prod_reg.prod) + (RND_W'(1) << (efpw_pkg::WEIGHT_SHIFT - 1));
        wsum = (rnd >> efpw_pkg::WEIGHT_SHIFT) + RND_W'(1);
        if (wsum > RND_W'(efpw_pkg::WEIGHT_MAX))
            result_next.weight = efpw_pkg::WEIGHT_MAX;
        else
            result_next.weight = efpw_pkg::WEIGHT_W'(wsum);
        result_next.saturation  = prod_reg.sat;
        result_next.exposedness = prod_reg.expo[efpw_pkg::GAUSS_W-1]
                                ? {efpw_pkg::FRAC_W{1'b1}}
                                : prod_reg.expo[efpw_pkg::FRAC_W-1:0];
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Payload registers run freely; only the valid bits need reset.
    always_ff @(posedge clk)
    begin
        st1_reg    <= st1_next;
        st2_reg    <= st2_next;
        st3_reg    <= st3_next;
        st4_reg    <= st4_next;
        sat_reg    <= sat_next;
        cs_reg     <= cs_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
        for (int j = 0; j <= efpw_pkg::SQRT_STEPS; j++)
        begin
            sq_rad_reg[j]  <= sq_rad_next[j];
            sq_rem_reg[j]  <= sq_rem_next[j];
            sq_root_reg[j] <= sq_root_next[j];
        end
        sq_expo_reg[0] <= st4_reg.expo;
        sq_con_reg[0]  <= st4_reg.contrast;
        for (int j = 1; j <= efpw_pkg::SQRT_STEPS; j++)
        begin
            sq_expo_reg[j] <= sq_expo_reg[j-1];
            sq_con_reg[j]  <= sq_con_reg[j-1];
        end
    end

    assign done   = vld_reg[efpw_pkg::LATENCY-1];
    assign result = result_reg;

endmodule

// File: hw/rtl/efpw_checker.sv
// Port-level assertions for the exposure-fusion pixel weight block,
// bound to the top level. Depends on efpw_pkg for payload types and latency.
module efpw_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input efpw_pkg::result_t result
);

    // The pipeline has no stall path, so it never refuses a transfer.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy == 1'b0)
        else $error("busy raised");

    // Every accepted pixel yields a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(efpw_pkg::LATENCY) done)
        else $error("result missing after accepted pixel");

    // No result appears without a matching accepted pixel.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(efpw_pkg::LATENCY) !done)
        else $error("result without accepted pixel");

    // The weight carries a one-LSB floor.
    a_weight_floor: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.weight != '0)
        else $error("weight below floor");

    // Zero saturation kills the product, leaving only the floor.
    a_flat_color: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.saturation == '0) |-> result.weight == 17'd1)
        else $error("weight nonzero product with zero saturation");

endmodule

bind exposure_fusion_pixel_weight efpw_checker u_efpw_checker (.*);
